FILE: hdl/olis_pkg.sv
// ----------------------------------------------------------------------------
// olis_pkg: shared types and constants of the ordered list
// Beat structs for both channels, operation and status codes, and the
// control group that is broadcast to every list cell.
// ----------------------------------------------------------------------------
package olis_pkg;

    // Default sizes
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 64;

    // Field widths on the ports
    localparam int FUNC_W      = 2;
    localparam int POS_W       = 8;
    localparam int KEY_FIELD_W = 64;
    localparam int STATUS_W    = 2;
    localparam int IDX_W       = 4;
    localparam int LEN_W       = 5;
    localparam int CAP_W       = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [POS_W-1:0]       position;
        logic [KEY_FIELD_W-1:0] key;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [IDX_W-1:0]       index;
        logic [KEY_FIELD_W-1:0] removed_key;
        logic [LEN_W-1:0]       length;
        logic                   is_empty;
        logic                   is_full;
    } out_beat_t;

    // Per-cycle command to the cell row
    typedef struct packed {
        logic ins_en;   // write new key at sel, shift cells above sel up
        logic del_en;   // shift cells at and above sel down
    } cell_ctrl_t;

endpackage

FILE: hdl/ordered_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_search: positional key list
// Row of key cells with insert, delete and search, one operation per beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry one operation beat (func, position, key);
//   m_valid/m_ready carry one result beat per operation.
//   cfg_we/cfg_wdata set the capacity; write it only while idle.
// Timing: the result passes the encode stage and then the output register
//   before it is presented. Insert and delete shift the cells at and above
//   the selected slot in the accept cycle, and search compares all cells at
//   once; the match flags are encoded in the following stage.
// Throughput: one beat per cycle while the result side takes beats.
// Stall: one operation can sit in the encode stage behind a result that is
//   waiting; with both held, s_ready drops until m_ready returns.
// Reset: aresetn (synchronous, active low) empties the list, sets the
//   capacity to 16 and drops m_valid. Key cells are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_search #(
    parameter int DEPTH     = olis_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = olis_pkg::KEY_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  olis_pkg::in_beat_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output olis_pkg::out_beat_t           m_data,
    input  logic                          cfg_we,
    input  logic [olis_pkg::CAP_W-1:0]    cfg_wdata
);
    import olis_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = $clog2(DEPTH);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
    localparam int FW    = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    // Control and config state
    logic [CAP_W-1:0] cap_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    // Encode stage
    logic                    p1_valid_reg;
    logic [STATUS_W-1:0]     p1_status_reg;
    logic [IDX_W-1:0]        p1_idx_reg;
    logic                    p1_search_reg;
    logic [KEY_WIDTH-1:0]    p1_removed_reg;
    logic [CW-1:0]           p1_len_reg;
    logic                    p1_empty_reg;
    logic                    p1_full_reg;
    logic [DEPTH-1:0]        p1_match_reg;

    // Output stage
    logic      m_valid_reg;
    out_beat_t m_data_reg;
    out_beat_t m_data_next;

    // Cell row
    logic [KEY_WIDTH-1:0] cell_key [DEPTH];
    logic [DEPTH-1:0]     cell_match;
    cell_ctrl_t           ctrl;
    logic [CW-1:0]        sel;

    logic                 accept;
    logic                 advance;
    logic [KEY_WIDTH-1:0] key_in;
    logic [CMP_W-1:0]     pos_w;
    logic [CMP_W-1:0]     cnt_w;
    logic [CMP_W-1:0]     at_w;
    logic                 full_now;
    logic                 ins_ok;
    logic                 del_ok;
    logic [STATUS_W-1:0]  status_now;
    logic [IDX_W-1:0]     idx_now;
    logic                 enc_found;
    logic [IDX_W-1:0]     enc_idx;

    // Handshake
    assign advance = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    // Decode the operation against the current count
    assign key_in   = s_data.key[KEY_WIDTH-1:0];
    assign pos_w    = CMP_W'(s_data.position);
    assign cnt_w    = CMP_W'(count_reg);
    assign at_w     = (pos_w < cnt_w) ? pos_w : cnt_w;
    assign sel      = at_w[CW-1:0];
    assign full_now = (FW'(count_reg) >= FW'(cap_reg)) || (count_reg >= DEPTH_CNT);
    assign ins_ok   = (s_data.func == FUNC_INSERT) && !full_now;
    assign del_ok   = (s_data.func == FUNC_DELETE) && (pos_w < cnt_w);

    assign ctrl.ins_en = accept && ins_ok;
    assign ctrl.del_en = accept && del_ok;

    always_comb begin
        status_now = STATUS_OK;
        idx_now    = '0;
        case (s_data.func)
            FUNC_INSERT: begin
                if (full_now) begin
                    status_now = STATUS_FULL;
                end else begin
                    idx_now = at_w[IDX_W-1:0];
                end
            end
            FUNC_DELETE: begin
                if (!del_ok) begin
                    status_now = STATUS_RANGE;
                end
            end
            default: begin
                status_now = STATUS_OK;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.ins_en) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.del_en) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Cell row, each slot wired to its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_WIDTH-1:0] lower;
        logic [KEY_WIDTH-1:0] upper;
        if (g == 0) begin : g_first
            assign lower = cell_key[g];
        end else begin : g_lo
            assign lower = cell_key[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign upper = cell_key[g];
        end else begin : g_hi
            assign upper = cell_key[g+1];
        end
        olis_cell #(
            .SLOT      (g),
            .KEY_WIDTH (KEY_WIDTH),
            .CW        (CW)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .sel       (sel),
            .count     (count_reg),
            .key_new   (key_in),
            .key_lower (lower),
            .key_upper (upper),
            .key_q     (cell_key[g]),
            .match     (cell_match[g])
        );
    end

    // Count and capacity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end else begin
            count_reg <= count_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Encode stage capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_status_reg  <= status_now;
            p1_idx_reg     <= idx_now;
            p1_search_reg  <= (s_data.func == FUNC_SEARCH);
            p1_removed_reg <= del_ok ? cell_key[sel[DW-1:0]] : '0;
            p1_len_reg     <= count_next;
            p1_empty_reg   <= (count_next == '0);
            p1_full_reg    <= (FW'(count_next) >= FW'(cap_reg)) ||
                              (count_next >= DEPTH_CNT);
            p1_match_reg   <= cell_match;
        end
    end

    olis_prio #(
        .DEPTH (DEPTH)
    ) u_prio (
        .match (p1_match_reg),
        .found (enc_found),
        .index (enc_idx)
    );

    // Result assembly
    always_comb begin
        m_data_next.status      = p1_status_reg;
        m_data_next.index       = p1_idx_reg;
        m_data_next.removed_key = KEY_FIELD_W'(p1_removed_reg);
        m_data_next.length      = LEN_W'(p1_len_reg);
        m_data_next.is_empty    = p1_empty_reg;
        m_data_next.is_full     = p1_full_reg;
        if (p1_search_reg) begin
            m_data_next.status = enc_found ? STATUS_OK : STATUS_NOT_FOUND;
            m_data_next.index  = enc_found ? enc_idx : '0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hdl/olis_cell.sv
// ----------------------------------------------------------------------------
// olis_cell: one slot of the list
// Holds one key, takes its lower or upper neighbor's key on a shift,
// loads the new key when selected, and flags an equal key for search.
// ----------------------------------------------------------------------------
module olis_cell #(
    parameter int SLOT      = 0,
    parameter int KEY_WIDTH = 64,
    parameter int CW        = 5
) (
    input  logic                     aclk,
    input  olis_pkg::cell_ctrl_t     ctrl,
    input  logic [CW-1:0]            sel,
    input  logic [CW-1:0]            count,
    input  logic [KEY_WIDTH-1:0]     key_new,
    input  logic [KEY_WIDTH-1:0]     key_lower,
    input  logic [KEY_WIDTH-1:0]     key_upper,
    output logic [KEY_WIDTH-1:0]     key_q,
    output logic                     match
);
    import olis_pkg::*;

    localparam logic [CW-1:0] MY_SLOT = CW'(SLOT);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;

    // Shift or load
    always_comb begin
        key_next = key_reg;
        if (ctrl.ins_en) begin
            if (MY_SLOT == sel) begin
                key_next = key_new;
            end else if (MY_SLOT > sel) begin
                key_next = key_lower;
            end
        end else if (ctrl.del_en) begin
            if (MY_SLOT >= sel) begin
                key_next = key_upper;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    // Only slots in use take part in search
    assign match = (MY_SLOT < count) && (key_reg == key_new);
    assign key_q = key_reg;

endmodule

FILE: hdl/olis_prio.sv
// ----------------------------------------------------------------------------
// olis_prio: lowest-index match encoder
// Turns the registered match flags of the cell row into a found flag and
// the lowest matching slot, reduced to the index field width.
// ----------------------------------------------------------------------------
module olis_prio #(
    parameter int DEPTH = 16
) (
    input  logic [DEPTH-1:0]            match,
    output logic                        found,
    output logic [olis_pkg::IDX_W-1:0]  index
);
    import olis_pkg::*;

    // Walk down so the lowest set flag wins
    always_comb begin
        index = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                index = IDX_W'(i);
            end
        end
    end

    assign found = |match;

endmodule

FILE: hdl/olis_checker.sv
// ----------------------------------------------------------------------------
// olis_checker: port-level checks of the ordered list
// Watches the channels of the top level over time; attached by bind.
// ----------------------------------------------------------------------------
module olis_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  olis_pkg::in_beat_t            s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  olis_pkg::out_beat_t           m_data
);
    import olis_pkg::*;

    // No result beat right after reset
    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result beat shown right after reset");

    // Input is held off only while a result waits
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with no result pending");

    // A stalled operation beat holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("operation beat changed while stalled");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // A refused insert always reports a full list
    a_full_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_FULL |-> m_data.is_full)
        else $error("insert refused but list not reported full");

endmodule

bind ordered_list_insert_delete_search olis_checker u_olis_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
